FILE: src/blpd_pkg.sv
// Shared types and constants for the button press and long press detector.
package blpd_pkg;

  localparam int unsigned LimitWidth = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned StateWidth = 3;
  localparam int unsigned RegIdxWidth = 8;

  localparam logic [LimitWidth-1:0] DebounceMsReset  = 16'd50;
  localparam logic [LimitWidth-1:0] LongPressMsReset = 16'd2000;

  localparam logic [RegIdxWidth-1:0] RegDebounceMs  = 8'd0;
  localparam logic [RegIdxWidth-1:0] RegLongPressMs = 8'd1;

  typedef struct packed {
    logic                 pin_level;
    logic [TimeWidth-1:0] now_ms;
  } step_in_t;

  typedef struct packed {
    logic [LimitWidth-1:0] debounce_ms;
    logic [LimitWidth-1:0] long_press_ms;
  } cfg_t;

endpackage

FILE: src/blpd_if.sv
// Handshake channels: input items, result items and register writes.
interface blpd_item_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;
  modport source (output valid, pin_level, now_ms, input ready);
  modport sink (input valid, pin_level, now_ms, output ready);
endinterface

interface blpd_result_if;
  logic       valid;
  logic       ready;
  logic       press_event;
  logic       long_press_event;
  logic [2:0] fsm_state;
  modport source (output valid, press_event, long_press_event, fsm_state, input ready);
  modport sink (input valid, press_event, long_press_event, fsm_state, output ready);
endinterface

interface blpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [15:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: src/button_press_long_press_detector_core.sv
// Top level: debounced button press and long press detector.
// A result is valid once its item has passed the input register, then the result register.
// Throughput: one item per cycle while result.ready keeps up; the phase and mark time update with each item.
// Reset (rst, synchronous): phase waits for release, mark time 0,
// debounce 50 ms, long press 2000 ms, both pipeline stages empty.
module button_press_long_press_detector_core
  import blpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  blpd_item_if.sink     item,
  blpd_result_if.source result,
  blpd_cfg_if.sink      cfg
);

  cfg_t     limits;
  step_in_t s_data;
  logic     s_valid;
  logic     advance;

  blpd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  blpd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .valid   (s_valid),
    .data    (s_data)
  );

  blpd_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_data  (s_data),
    .limits   (limits),
    .advance  (advance),
    .result   (result)
  );

endmodule

FILE: src/blpd_cfg.sv
// Configuration registers: debounce and long press limits.
module blpd_cfg
  import blpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  blpd_cfg_if.sink     cfg,
  output cfg_t         limits
);

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign limits    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms   <= DebounceMsReset;
      regs.long_press_ms <= LongPressMsReset;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        RegDebounceMs:  regs.debounce_ms   <= cfg.data;
        RegLongPressMs: regs.long_press_ms <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/blpd_in_stage.sv
// Input register stage for pin samples.
module blpd_in_stage
  import blpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  blpd_item_if.sink  item,
  input  logic       advance,
  output logic       valid,
  output step_in_t   data
);

  logic accept;

  assign item.ready = !valid || advance;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
    if (accept) begin
      data.pin_level <= item.pin_level;
      data.now_ms    <= item.now_ms;
    end
  end

endmodule

FILE: src/blpd_fsm.sv
// Press detection state machine with result register.
module blpd_fsm
  import blpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  step_in_t      in_data,
  input  cfg_t          limits,
  output logic          advance,
  blpd_result_if.source result
);

  typedef enum logic [StateWidth-1:0] {
    ARMED        = 3'd0,
    SHORT        = 3'd1,
    DEBOUNCE     = 3'd2,
    HOLD         = 3'd3,
    LONG         = 3'd4,
    LATCHED      = 3'd5,
    RELEASE      = 3'd6,
    REL_DEBOUNCE = 3'd7
  } phase_t;

  phase_t               phase, phase_next;
  logic [TimeWidth-1:0] mark_time, mark_time_next;
  logic                 out_valid;
  logic                 press_event, press_event_next;
  logic                 long_event, long_event_next;
  logic [TimeWidth-1:0] elapsed;
  logic                 pressed, fire, debounce_done, long_done;

  assign advance       = !out_valid || result.ready;
  assign fire          = in_valid && advance;
  assign pressed       = !in_data.pin_level;
  assign elapsed       = in_data.now_ms - mark_time;
  assign debounce_done = elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, limits.debounce_ms};
  assign long_done     = elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, limits.long_press_ms};

  always_comb begin
    phase_next       = phase;
    mark_time_next   = mark_time;
    press_event_next = 1'b0;
    long_event_next  = 1'b0;
    case (phase)
      ARMED: begin
        if (pressed) phase_next = SHORT;
      end
      SHORT: begin
        mark_time_next   = in_data.now_ms;
        press_event_next = 1'b1;
        phase_next       = DEBOUNCE;
      end
      DEBOUNCE: begin
        if (debounce_done) phase_next = HOLD;
      end
      HOLD: begin
        if (!pressed) phase_next = RELEASE;
        else if (long_done) phase_next = LONG;
      end
      LONG: begin
        mark_time_next  = in_data.now_ms;
        long_event_next = 1'b1;
        phase_next      = LATCHED;
      end
      LATCHED: begin
        if (!pressed) phase_next = RELEASE;
      end
      RELEASE: begin
        mark_time_next = in_data.now_ms;
        phase_next     = REL_DEBOUNCE;
      end
      REL_DEBOUNCE: begin
        if (debounce_done) phase_next = ARMED;
      end
      default: phase_next = LATCHED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= LATCHED;
      mark_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase     <= phase_next;
        mark_time <= mark_time_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      press_event <= press_event_next;
      long_event  <= long_event_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.press_event      = press_event;
  assign result.long_press_event = long_event;
  assign result.fsm_state        = phase;

endmodule
